// ===== src/spadd_pkg.sv =====
// Shared types and constants for the sparse polynomial add/merge unit.
// No dependencies.
package spadd_pkg;

   localparam int MAX_TERMS_DEFAULT = 32;

   localparam int COEFF_W = 16;
   localparam int EXPO_W  = 8;
   localparam int SUM_W   = COEFF_W + 1;

   // Request opcodes
   localparam logic [1:0] OP_APPEND_A = 2'd0;
   localparam logic [1:0] OP_APPEND_B = 2'd1;
   localparam logic [1:0] OP_SUM      = 2'd2;

   typedef struct packed {
      logic signed [COEFF_W-1:0] coeff;
      logic [EXPO_W-1:0]         expo;
   } term_type;

   function automatic logic signed [SUM_W-1:0] sext_coeff(input logic signed [COEFF_W-1:0] c);
      return SUM_W'(c);
   endfunction

endpackage

// ===== src/sparse_polynomial_add_merge_unit.sv =====
// Sparse polynomial add/merge unit: two term-list memories and a merge sequencer.
// Depends on spadd_pkg and spadd_term_store.
//
//   channel | dir | fields                                                  | handshake
//   req_    | in  | op, term_coeff, term_expo                               | valid/ready
//   rsp_    | out | sum_coeff, sum_expo, last_term, no_terms, append_dropped | valid/ready
//
// Append: one transfer out (loaded straight into the output register).
// Sum: each emitted term takes a memory read (S_FETCH), then compare/add (S_STEP);
//   the empty case loads a no_terms result straight into the output register.
// A request is taken only when the sequencer is idle and the output register is
//   free or being drained in the same cycle; a stalled rsp_ holds the merge.
// Reset is synchronous; it clears counts, pointers and valid flags. Stored terms
//   are not cleared and are never used beyond the counts.
module sparse_polynomial_add_merge_unit #(
   parameter int MAX_TERMS = spadd_pkg::MAX_TERMS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_op,
   input  logic signed [spadd_pkg::COEFF_W-1:0]  req_term_coeff,
   input  logic [spadd_pkg::EXPO_W-1:0]          req_term_expo,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [spadd_pkg::SUM_W-1:0]    rsp_sum_coeff,
   output logic [spadd_pkg::EXPO_W-1:0]          rsp_sum_expo,
   output logic                                  rsp_last_term,
   output logic                                  rsp_no_terms,
   output logic                                  rsp_append_dropped
);
   import spadd_pkg::*;

   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;   // read addresses settle into memories
   localparam logic [1:0] S_STEP  = 2'd2;   // compare heads, emit one term

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] a_count_ff, a_count_in, b_count_ff, b_count_in;
   logic [CW-1:0] a_ptr_ff, a_ptr_in, b_ptr_ff, b_ptr_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]  rsp_coeff_ff, rsp_coeff_in;
   logic [EXPO_W-1:0]        rsp_expo_ff, rsp_expo_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_none_ff, rsp_none_in;
   logic                     rsp_drop_ff, rsp_drop_in;

   logic     a_we, b_we;
   term_type new_term, a_head, b_head;

   logic slot_free, accept;
   logic a_has, b_has, expo_eq, take_a, take_b;
   logic [CW-1:0] a_ptr_nx, b_ptr_nx;

   assign new_term.coeff = req_term_coeff;
   assign new_term.expo  = req_term_expo;

   spadd_term_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_store_a (
      .clock  (clock),
      .wr_en  (a_we),
      .wr_addr(a_count_ff[AW-1:0]),
      .wr_data(new_term),
      .rd_addr(a_ptr_ff[AW-1:0]),
      .rd_data(a_head)
   );

   spadd_term_store #(.DEPTH(MAX_TERMS), .AW(AW)) u_store_b (
      .clock  (clock),
      .wr_en  (b_we),
      .wr_addr(b_count_ff[AW-1:0]),
      .wr_data(new_term),
      .rd_addr(b_ptr_ff[AW-1:0]),
      .rd_data(b_head)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   // merge decision on the current heads
   assign a_has   = a_ptr_ff < a_count_ff;
   assign b_has   = b_ptr_ff < b_count_ff;
   assign expo_eq = a_has && b_has && (a_head.expo == b_head.expo);
   assign take_a  = expo_eq || (a_has && (!b_has || (a_head.expo > b_head.expo)));
   assign take_b  = expo_eq || !take_a;
   assign a_ptr_nx = a_ptr_ff + CW'(take_a);
   assign b_ptr_nx = b_ptr_ff + CW'(take_b);

   always_comb begin
      state_in     = state_ff;
      a_count_in   = a_count_ff;
      b_count_in   = b_count_ff;
      a_ptr_in     = a_ptr_ff;
      b_ptr_in     = b_ptr_ff;
      a_we         = 1'b0;
      b_we         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_coeff_in = rsp_coeff_ff;
      rsp_expo_in  = rsp_expo_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_drop_in  = rsp_drop_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_op == OP_APPEND_A || req_op == OP_APPEND_B) begin
                  rsp_valid_in = 1'b1;
                  rsp_coeff_in = '0;
                  rsp_expo_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_none_in  = 1'b0;
                  if (req_op == OP_APPEND_A) begin
                     rsp_drop_in = !(a_count_ff < MAX_CNT);
                     if (a_count_ff < MAX_CNT) begin
                        a_we       = 1'b1;
                        a_count_in = a_count_ff + CW'(1);
                     end
                  end else begin
                     rsp_drop_in = !(b_count_ff < MAX_CNT);
                     if (b_count_ff < MAX_CNT) begin
                        b_we       = 1'b1;
                        b_count_in = b_count_ff + CW'(1);
                     end
                  end
               end else if (req_op == OP_SUM) begin
                  if (a_count_ff == '0 && b_count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_coeff_in = '0;
                     rsp_expo_in  = '0;
                     rsp_last_in  = 1'b1;
                     rsp_none_in  = 1'b1;
                     rsp_drop_in  = 1'b0;
                  end else begin
                     a_ptr_in = '0;
                     b_ptr_in = '0;
                     state_in = S_FETCH;
                  end
               end else begin
                  // unused opcode: dropped silently
                  state_in = S_IDLE;
               end
            end
         end
         S_FETCH: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_coeff_in = (take_a ? sext_coeff(a_head.coeff) : SUM_W'(0))
                            + (take_b ? sext_coeff(b_head.coeff) : SUM_W'(0));
               rsp_expo_in  = take_a ? a_head.expo : b_head.expo;
               rsp_last_in  = (a_ptr_nx >= a_count_ff) && (b_ptr_nx >= b_count_ff);
               rsp_none_in  = 1'b0;
               rsp_drop_in  = 1'b0;
               a_ptr_in     = a_ptr_nx;
               b_ptr_in     = b_ptr_nx;
               state_in     = ((a_ptr_nx >= a_count_ff) && (b_ptr_nx >= b_count_ff))
                              ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_count_ff   <= '0;
         b_count_ff   <= '0;
         a_ptr_ff     <= '0;
         b_ptr_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_count_ff   <= a_count_in;
         b_count_ff   <= b_count_in;
         a_ptr_ff     <= a_ptr_in;
         b_ptr_ff     <= b_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      rsp_coeff_ff <= rsp_coeff_in;
      rsp_expo_ff  <= rsp_expo_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sum_coeff      = rsp_coeff_ff;
   assign rsp_sum_expo       = rsp_expo_ff;
   assign rsp_last_term      = rsp_last_ff;
   assign rsp_no_terms       = rsp_none_ff;
   assign rsp_append_dropped = rsp_drop_ff;

endmodule

// ===== src/spadd_term_store.sv =====
// One term list: synchronous single-write, single-read memory of terms.
// Depends on spadd_pkg.
module spadd_term_store #(
   parameter int DEPTH = spadd_pkg::MAX_TERMS_DEFAULT,
   parameter int AW    = 5
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  spadd_pkg::term_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output spadd_pkg::term_type rd_data
);
   import spadd_pkg::*;

   term_type mem [DEPTH];
   term_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/spadd_checker.sv =====
// Port-level checks for the sparse polynomial add/merge unit, bound to the top level.
// Depends on spadd_pkg and sparse_polynomial_add_merge_unit.
module spadd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [1:0]                           req_op,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [spadd_pkg::SUM_W-1:0]   rsp_sum_coeff,
   input logic [spadd_pkg::EXPO_W-1:0]         rsp_sum_expo,
   input logic                                 rsp_last_term,
   input logic                                 rsp_no_terms,
   input logic                                 rsp_append_dropped
);
   import spadd_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum_coeff)
         && $stable(rsp_sum_expo) && $stable(rsp_last_term))
      else $error("result changed while stalled");

   // an accepted append yields a final single result in the next cycle
   a_append_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_APPEND_A || req_op == OP_APPEND_B)
         |=> rsp_valid && rsp_last_term && !rsp_no_terms)
      else $error("append result missing");

   // empty-sum result is final with zero term fields
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_terms |-> rsp_last_term && !rsp_append_dropped
         && rsp_sum_coeff == '0 && rsp_sum_expo == '0)
      else $error("malformed empty-sum result");

   // no request taken while a result sits unaccepted
   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output blocked");

endmodule

bind sparse_polynomial_add_merge_unit spadd_checker u_spadd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_op            (req_op),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_sum_coeff     (rsp_sum_coeff),
   .rsp_sum_expo      (rsp_sum_expo),
   .rsp_last_term     (rsp_last_term),
   .rsp_no_terms      (rsp_no_terms),
   .rsp_append_dropped(rsp_append_dropped)
);
